// ----- sv/aes_kx_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_kx_pkg
// Types, constants and helper functions for the AES-128 key expansion block.
// ----------------------------------------------------------------------------
package aes_kx_pkg;

  localparam int ROUNDS              = 10;
  localparam int RIDX_W              = 4;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(ROUNDS);
  localparam logic [7:0]        RC_INIT    = 8'h01;
  localparam logic [7:0]        RC_POLY    = 8'h1b;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } kx_req_t;

  typedef struct packed {
    logic [RIDX_W-1:0] round_index;
    logic [63:0]       round_key_hi;
    logic [63:0]       round_key_lo;
    logic              last;
  } kx_res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? RC_POLY : 8'h00);
  endfunction

  // One step of the schedule: four new words from the previous round key.
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0]   rc);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
    w0 = k[127:96] ^ t;
    w1 = k[95:64]  ^ w0;
    w2 = k[63:32]  ^ w1;
    w3 = k[31:0]   ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- sv/aes128_key_expansion.sv -----
// ----------------------------------------------------------------------------
// aes128_key_expansion
// AES-128 key schedule: one cipher key in, eleven round keys out.
// ----------------------------------------------------------------------------
//  channel   handshake        payload                                    dir
//  request   start / busy     req    {key_hi, key_lo}                    in
//  result    done (strobe)    result {round_index, round_key_hi/lo, last} out
//
//  Each key occupies the round unit for one run, one round key per cycle;
//  a queued key starts as soon as the previous run ends, with no gap between runs.
//  On an idle block a taken request passes the queue and the key register before round 0 appears.
//  busy is high only while the request queue (QUEUE_DEPTH keys) is full.
//  Results are strobed for a single cycle; the receiver cannot stall.
//  Synchronous reset empties the queue and aborts any run in progress.
// ----------------------------------------------------------------------------
module aes128_key_expansion #(
  parameter int QUEUE_DEPTH = aes_kx_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aes_kx_pkg::kx_req_t req,
  output logic                done,
  output aes_kx_pkg::kx_res_t result
);
  import aes_kx_pkg::*;

  logic    head_valid;
  kx_req_t head;
  logic    pop;

  aes_kx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  aes_kx_round u_round (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

  // a run never breaks off before its last round key
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done && (result.round_index == $past(result.round_index) + 1'b1))
    else $error("round key sequence broken");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> result.round_index == LAST_ROUND)
    else $error("last flag on wrong round");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> result.round_index == '0)
    else $error("run does not start at round 0");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    done && result.last ##1 done |-> result.round_index == '0)
    else $error("new run does not start at round 0");

endmodule

// ----- sv/aes_kx_queue.sv -----
// ----------------------------------------------------------------------------
// aes_kx_queue
// Front end: takes key requests and holds them until the round unit is free.
// ----------------------------------------------------------------------------
module aes_kx_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  aes_kx_pkg::kx_req_t req,
  output logic              busy,
  output logic              head_valid,
  output aes_kx_pkg::kx_req_t head,
  input  logic              pop
);
  import aes_kx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kx_req_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            do_pop;

  assign busy       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign push       = start && !busy;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/aes_kx_round.sv -----
// ----------------------------------------------------------------------------
// aes_kx_round
// Back end: expands one key per run, one round key per cycle, registered out.
// ----------------------------------------------------------------------------
module aes_kx_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  aes_kx_pkg::kx_req_t head,
  output logic                pop,
  output logic                done,
  output aes_kx_pkg::kx_res_t result
);
  import aes_kx_pkg::*;

  logic              active;
  logic [RIDX_W-1:0] round;
  logic [7:0]        rc;
  logic [127:0]      cur_key;
  logic [127:0]      cur_key_next;
  logic              at_last;
  logic              load;

  assign at_last      = (round == LAST_ROUND);
  // pick up the next key in the cycle round 10 is being registered, so runs abut
  assign load         = head_valid && (!active || at_last);
  assign pop          = load;
  assign cur_key_next = next_round_key(cur_key, rc);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= active;
      active <= load || (active && !at_last);
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.round_index  <= round;
      result.round_key_hi <= cur_key[127:64];
      result.round_key_lo <= cur_key[63:0];
      result.last         <= at_last;
    end
    if (load) begin
      cur_key <= {head.key_hi, head.key_lo};
      round   <= '0;
      rc      <= RC_INIT;
    end else if (active) begin
      cur_key <= cur_key_next;
      round   <= round + 1'b1;
      rc      <= gf_double(rc);
    end
  end

endmodule
